/* hdl/sprite_frame_sequencer_defines.svh */
// Assertion macros shared by the sequencer RTL.
`ifndef SPRITE_FRAME_SEQUENCER_DEFINES_SVH
`define SPRITE_FRAME_SEQUENCER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SFS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sequencer check failed");

// Check that cons holds in the cycle after ante.
`define SFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sequencer check failed");

`endif

/* hdl/sfs_pkg.sv */
`default_nettype none

package sfs_pkg;

  localparam int DUR_W      = 16;
  localparam int FRAME_W    = 6;
  localparam int COUNT_W    = 7;
  localparam int ACC_W      = 17;
  localparam int TICK_W     = 16;
  localparam int DVD_W      = 18;
  localparam int DSR_W      = 16;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int MAX_FRAMES_DEF = 64;

  localparam logic [DUR_W-1:0]   DUR_RST   = 16'd1;
  localparam logic [FRAME_W-1:0] FIRST_RST = 6'd0;
  localparam logic [COUNT_W-1:0] COUNT_RST = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_PLAY  = 2'd1,
    CMD_PAUSE = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_DURATION = 2'd0,
    CFG_FIRST_FRAME    = 2'd1,
    CFG_FRAME_COUNT    = 2'd2,
    CFG_PING_PONG      = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_TDIV = 2'd1,
    S_FMOD = 2'd2,
    S_DONE = 2'd3
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

/* hdl/sfs_chan_if.sv */
`default_nettype none

interface sfs_in_if;
  logic                          valid;
  logic                          ready;
  logic [sfs_pkg::CMD_W-1:0]     cmd;
  logic [sfs_pkg::TICK_W-1:0]    elapsed_ticks;
  modport source (output valid, output cmd, output elapsed_ticks, input ready);
  modport sink   (input valid, input cmd, input elapsed_ticks, output ready);
endinterface

interface sfs_out_if;
  logic                          valid;
  logic                          ready;
  logic [sfs_pkg::FRAME_W-1:0]   frame_index;
  logic                          is_playing;
  logic                          moving_back;
  modport source (output valid, output frame_index, output is_playing,
                  output moving_back, input ready);
  modport sink   (input valid, input frame_index, input is_playing,
                  input moving_back, output ready);
endinterface

interface sfs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sfs_pkg::CFG_IDX_W-1:0]   index;
  logic [sfs_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hdl/sfs_div.sv */
`default_nettype none

module sfs_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [sfs_pkg::DVD_W-1:0]    dividend,
  input  wire logic [sfs_pkg::DSR_W-1:0]    divisor,
  output sfs_pkg::div_sts_t                 sts,
  output logic      [sfs_pkg::DVD_W-1:0]    quotient,
  output logic      [sfs_pkg::DSR_W-1:0]    remainder
);

  localparam int CNT_W = $clog2(sfs_pkg::DVD_W);

  logic [sfs_pkg::DVD_W-1:0] dvd_r, dvd_nxt;
  logic [sfs_pkg::DSR_W-1:0] dsr_r, dsr_nxt;
  logic [sfs_pkg::DSR_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [sfs_pkg::DSR_W:0]   trial;
  logic [sfs_pkg::DSR_W:0]   diff;
  logic                      qbit;

  always_comb begin
    trial = {rem_r, dvd_r[sfs_pkg::DVD_W-1]};
    diff  = trial - {1'b0, dsr_r};
    qbit  = (trial >= {1'b0, dsr_r});
  end

  always_comb begin
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start && !busy_r) begin
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(sfs_pkg::DVD_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[sfs_pkg::DVD_W-2:0], qbit};
      rem_nxt = qbit ? diff[sfs_pkg::DSR_W-1:0] : trial[sfs_pkg::DSR_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

/* hdl/sprite_frame_sequencer.sv */
// Sprite animation frame sequencer.
// in_ch carries one request per command: tick (with elapsed_ticks), play,
// pause or stop. out_ch returns one result per request: the frame index to
// show, the playing flag and the ping-pong direction after the update.
// cfg_ch writes frame_duration, first_frame, frame_count and ping_pong by index
// and is always ready; the user must ensure it is written only while the block
// is idle; the block does not enforce this. One request is worked on at a time.
// Play, pause, stop and non-advancing ticks go straight to the done state. An
// advancing tick runs one shared 18-step restoring divider for time/duration
// and, unless ping-pong runs backward or span is 0, a second frame modulo pass.
// in_ch is ready again as soon as the result is in the output register, so
// the next request may start while the result waits to be taken.
// If out_ch stalls while a result is still held, the block holds the newer
// result until the old one is taken.
// After reset: not playing, frame 0, time 0, forward, duration 1, first frame
// 0, 64 frames, loop mode; out_ch holds no result.
`default_nettype none

`include "sprite_frame_sequencer_defines.svh"

module sprite_frame_sequencer #(
  parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  sfs_in_if.sink    in_ch,
  sfs_out_if.source out_ch,
  sfs_cfg_if.sink   cfg_ch
);

  localparam int SPAN_W = $clog2(MAX_FRAMES + 1);

  sfs_pkg::state_t state_r, state_nxt;

  logic [sfs_pkg::DUR_W-1:0]   dur_r;
  logic [sfs_pkg::FRAME_W-1:0] first_r;
  logic [sfs_pkg::COUNT_W-1:0] count_r;
  logic                        pp_r;

  logic [sfs_pkg::FRAME_W-1:0] cur_r, cur_nxt;
  logic [sfs_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic                        back_r, back_nxt;
  logic                        run_r, run_nxt;

  logic                        out_valid_r;
  logic [sfs_pkg::FRAME_W-1:0] out_frame_r;
  logic                        out_play_r;
  logic                        out_back_r;

  sfs_pkg::cmd_t               cmd;
  logic                        in_fire;
  logic                        in_ready;
  logic                        out_load;
  logic                        tick_go;
  logic                        need_mod;
  logic                        back_hit;
  logic [sfs_pkg::ACC_W-1:0]   acc_sum;
  logic [sfs_pkg::COUNT_W:0]   span_raw;
  logic [SPAN_W-1:0]           span;
  logic [sfs_pkg::ACC_W-1:0]   q;
  logic [sfs_pkg::DVD_W-1:0]   frame_sum;

  logic                        div_start;
  logic [sfs_pkg::DVD_W-1:0]   div_dvd;
  logic [sfs_pkg::DSR_W-1:0]   div_dsr;
  sfs_pkg::div_sts_t           div_sts;
  logic [sfs_pkg::DVD_W-1:0]   div_quo;
  logic [sfs_pkg::DSR_W-1:0]   div_rem;

  sfs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .sts       (div_sts),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    cmd       = sfs_pkg::cmd_t'(in_ch.cmd);
    in_fire   = in_ch.valid && in_ready;
    acc_sum   = acc_r + sfs_pkg::ACC_W'(in_ch.elapsed_ticks);
    tick_go   = run_r && (acc_r < {1'b0, dur_r});
    span_raw  = {2'b00, first_r} + {1'b0, count_r};
    span      = (32'(span_raw) > 32'(MAX_FRAMES)) ? SPAN_W'(MAX_FRAMES)
                                                  : SPAN_W'(span_raw);
    q         = div_quo[sfs_pkg::ACC_W-1:0];
    frame_sum = sfs_pkg::DVD_W'(cur_r) + sfs_pkg::DVD_W'(q);
    back_hit  = (sfs_pkg::DVD_W'(q) + sfs_pkg::DVD_W'(first_r)) >=
                sfs_pkg::DVD_W'(cur_r);
    need_mod  = !(pp_r && back_r) && (span != '0);
  end

  // handshake and divider control of the sequencer
  always_comb begin
    in_ready  = (state_r == sfs_pkg::S_IDLE);
    out_load  = (state_r == sfs_pkg::S_DONE) && (!out_valid_r || out_ch.ready);
    div_start = 1'b0;
    div_dvd   = frame_sum;
    div_dsr   = sfs_pkg::DSR_W'(span);
    if (state_r == sfs_pkg::S_IDLE) begin
      div_dvd   = {1'b0, acc_sum};
      div_dsr   = dur_r;
      div_start = in_fire && (cmd == sfs_pkg::CMD_TICK) && tick_go;
    end else if (state_r == sfs_pkg::S_TDIV) begin
      div_start = div_sts.done && need_mod;
    end
  end

  // next state and state update
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    acc_nxt   = acc_r;
    back_nxt  = back_r;
    run_nxt   = run_r;
    unique case (state_r)
      sfs_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = sfs_pkg::S_DONE;
          unique case (cmd)
            sfs_pkg::CMD_TICK: begin
              if (tick_go) begin
                acc_nxt   = acc_sum;
                state_nxt = sfs_pkg::S_TDIV;
              end
            end
            sfs_pkg::CMD_PLAY:  run_nxt = 1'b1;
            sfs_pkg::CMD_PAUSE: run_nxt = 1'b0;
            sfs_pkg::CMD_STOP: begin
              run_nxt = 1'b0;
              cur_nxt = first_r;
              acc_nxt = '0;
            end
          endcase
        end
      end
      sfs_pkg::S_TDIV: begin
        if (div_sts.done) begin
          acc_nxt = sfs_pkg::ACC_W'(div_rem);
          if (pp_r && back_r) begin
            state_nxt = sfs_pkg::S_DONE;
            if (back_hit) begin
              cur_nxt  = first_r;
              back_nxt = 1'b0;
            end else begin
              cur_nxt = cur_r - q[sfs_pkg::FRAME_W-1:0];
            end
          end else if (span == '0) begin
            state_nxt = sfs_pkg::S_DONE;
            cur_nxt   = first_r;
          end else begin
            state_nxt = sfs_pkg::S_FMOD;
          end
        end
      end
      sfs_pkg::S_FMOD: begin
        if (div_sts.done) begin
          state_nxt = sfs_pkg::S_DONE;
          if (!pp_r) begin
            cur_nxt = (div_rem == '0) ? first_r : div_rem[sfs_pkg::FRAME_W-1:0];
          end else begin
            cur_nxt = div_rem[sfs_pkg::FRAME_W-1:0];
            if (div_rem == sfs_pkg::DSR_W'(span) - 16'd1) begin
              back_nxt = 1'b1;
            end
          end
        end
      end
      sfs_pkg::S_DONE: begin
        if (out_load) begin
          state_nxt = sfs_pkg::S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfs_pkg::S_IDLE;
      cur_r       <= '0;
      acc_r       <= '0;
      back_r      <= 1'b0;
      run_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      acc_r   <= acc_nxt;
      back_r  <= back_nxt;
      run_r   <= run_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_frame_r <= cur_r;
      out_play_r  <= run_r;
      out_back_r  <= back_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r   <= sfs_pkg::DUR_RST;
      first_r <= sfs_pkg::FIRST_RST;
      count_r <= sfs_pkg::COUNT_RST;
      pp_r    <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (sfs_pkg::cfg_idx_t'(cfg_ch.index))
        sfs_pkg::CFG_FRAME_DURATION: dur_r   <= cfg_ch.data[sfs_pkg::DUR_W-1:0];
        sfs_pkg::CFG_FIRST_FRAME:    first_r <= cfg_ch.data[sfs_pkg::FRAME_W-1:0];
        sfs_pkg::CFG_FRAME_COUNT:    count_r <= cfg_ch.data[sfs_pkg::COUNT_W-1:0];
        sfs_pkg::CFG_PING_PONG:      pp_r    <= cfg_ch.data[0];
      endcase
    end
  end

  assign in_ch.ready        = in_ready;
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.frame_index = out_frame_r;
  assign out_ch.is_playing  = out_play_r;
  assign out_ch.moving_back = out_back_r;

  `SFS_ASSERT_NEXT(a_leave_idle, in_fire, state_r != sfs_pkg::S_IDLE)
  `SFS_ASSERT_SAME(a_done_in_div, div_sts.done,
                   state_r == sfs_pkg::S_TDIV || state_r == sfs_pkg::S_FMOD)
  `SFS_ASSERT_SAME(a_start_free, div_start, !div_sts.busy)
  `SFS_ASSERT_NEXT(a_load_frame, out_load,
                   out_valid_r && out_frame_r == $past(cur_r))

endmodule

`default_nettype wire

/* test/tb_sprite_frame_sequencer.sv */
`timescale 1ns / 100ps

module tb_sprite_frame_sequencer;

  localparam int CLK_PERIOD         = 8;
  localparam int RESET_CYCLES       = 5;
  localparam int SPAN_LIMIT         = sfs_pkg::MAX_FRAMES_DEF;
  localparam int RESULT_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT     = 4000;
  localparam int DRAIN_CYCLES       = 50;
  localparam int RANDOM_PHASES      = 12;
  localparam int PHASE_REQUESTS     = 100;
  localparam int STALL_REQUESTS     = 40;

  typedef struct packed {
    logic [sfs_pkg::FRAME_W-1:0] frame_index;
    logic                        is_playing;
    logic                        moving_back;
  } frame_status_t;

  logic clk = 1'b0;
  logic rst_n;

  sfs_in_if  in_ch ();
  sfs_out_if out_ch ();
  sfs_cfg_if cfg_ch ();

  sprite_frame_sequencer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  logic [sfs_pkg::DUR_W-1:0]   cfg_duration  = sfs_pkg::DUR_RST;
  logic [sfs_pkg::FRAME_W-1:0] cfg_first     = sfs_pkg::FIRST_RST;
  logic [sfs_pkg::COUNT_W-1:0] cfg_count     = sfs_pkg::COUNT_RST;
  logic                        cfg_pingpong  = 1'b0;

  logic [sfs_pkg::FRAME_W-1:0] shown_frame   = '0;
  logic [sfs_pkg::ACC_W-1:0]   tick_accum    = '0;
  logic                        reverse_dir   = 1'b0;
  logic                        playing       = 1'b0;

  frame_status_t expected_status_q[$];
  int unsigned   requests_sent  = 0;
  int unsigned   results_seen   = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   idle_cycles    = 0;
  bit            sender_idle    = 1'b0;
  bit            receiver_idle  = 1'b0;
  bit            hold_results   = 1'b0;

  function automatic void move_frames(input int unsigned steps);
    int unsigned span;
    int unsigned pos;
    int          back_pos;
    span = cfg_first + cfg_count;
    if (span > SPAN_LIMIT) span = SPAN_LIMIT;
    if (cfg_pingpong && reverse_dir) begin
      back_pos = int'(shown_frame) - int'(steps);
      if (back_pos <= int'(cfg_first)) begin
        shown_frame = cfg_first;
        reverse_dir = 1'b0;
      end else begin
        shown_frame = back_pos[sfs_pkg::FRAME_W-1:0];
      end
    end else if (span == 0) begin
      shown_frame = cfg_first;
    end else begin
      pos = (shown_frame + steps) % span;
      if (!cfg_pingpong && pos == 0) pos = cfg_first;
      if (cfg_pingpong && pos == span - 1) reverse_dir = 1'b1;
      shown_frame = pos[sfs_pkg::FRAME_W-1:0];
    end
  endfunction

  function automatic void apply_tick(input logic [sfs_pkg::TICK_W-1:0] ticks);
    int unsigned total;
    int unsigned whole;
    if (!playing || tick_accum >= cfg_duration) return;
    total = (tick_accum + ticks) & ((1 << sfs_pkg::ACC_W) - 1);
    whole = total / cfg_duration;
    tick_accum = sfs_pkg::ACC_W'(total - whole * cfg_duration);
    move_frames(whole);
  endfunction

  function automatic frame_status_t next_status(input sfs_pkg::cmd_t op,
                                                input logic [sfs_pkg::TICK_W-1:0] ticks);
    frame_status_t status;
    case (op)
      sfs_pkg::CMD_TICK:  apply_tick(ticks);
      sfs_pkg::CMD_PLAY:  playing = 1'b1;
      sfs_pkg::CMD_PAUSE: playing = 1'b0;
      sfs_pkg::CMD_STOP: begin
        playing     = 1'b0;
        shown_frame = cfg_first;
        tick_accum  = '0;
      end
      default: ;
    endcase
    status.frame_index = shown_frame;
    status.is_playing  = playing;
    status.moving_back = reverse_dir;
    return status;
  endfunction

  always @(posedge clk) begin : status_monitor
    frame_status_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_status_q.size() == 0) begin
          $error("unexpected result: frame_index %0d is_playing %0b moving_back %0b",
                 out_ch.frame_index, out_ch.is_playing, out_ch.moving_back);
          mismatch_count++;
        end else begin
          want = expected_status_q.pop_front();
          if (out_ch.frame_index !== want.frame_index) begin
            $error("frame_index: expected %0d, actual %0d", want.frame_index,
                   out_ch.frame_index);
            mismatch_count++;
          end
          if (out_ch.is_playing !== want.is_playing) begin
            $error("is_playing: expected %0b, actual %0b", want.is_playing,
                   out_ch.is_playing);
            mismatch_count++;
          end
          if (out_ch.moving_back !== want.moving_back) begin
            $error("moving_back: expected %0b, actual %0b", want.moving_back,
                   out_ch.moving_back);
            mismatch_count++;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (sfs_pkg::cfg_idx_t'(cfg_ch.index))
          sfs_pkg::CFG_FRAME_DURATION: cfg_duration = cfg_ch.data[sfs_pkg::DUR_W-1:0];
          sfs_pkg::CFG_FIRST_FRAME:    cfg_first    = cfg_ch.data[sfs_pkg::FRAME_W-1:0];
          sfs_pkg::CFG_FRAME_COUNT:    cfg_count    = cfg_ch.data[sfs_pkg::COUNT_W-1:0];
          sfs_pkg::CFG_PING_PONG:      cfg_pingpong = cfg_ch.data[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        expected_status_q.push_back(next_status(sfs_pkg::cmd_t'(in_ch.cmd),
                                                in_ch.elapsed_ticks));
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("sprite_frame_sequencer regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned idle_gap(input bit enabled);
    int unsigned r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin : result_sink
    int unsigned gap;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        out_ch.ready <= 1'b0;
        repeat (RESULT_HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
        out_ch.ready <= 1'b1;
      end else begin
        gap = idle_gap(receiver_idle);
        if (gap != 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(input sfs_pkg::cmd_t op,
                              input logic [sfs_pkg::TICK_W-1:0] ticks);
    int unsigned gap;
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= op;
    in_ch.elapsed_ticks <= ticks;
    do @(posedge clk); while (!in_ch.ready);
    requests_sent++;
    gap = idle_gap(sender_idle);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_seen != requests_sent);
  endtask

  task automatic write_register(input sfs_pkg::cfg_idx_t idx,
                                input logic [sfs_pkg::CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic load_settings(input logic [sfs_pkg::DUR_W-1:0] duration,
                               input logic [sfs_pkg::FRAME_W-1:0] first,
                               input logic [sfs_pkg::COUNT_W-1:0] count,
                               input bit pingpong);
    write_register(sfs_pkg::CFG_FRAME_DURATION, duration);
    write_register(sfs_pkg::CFG_FIRST_FRAME, sfs_pkg::CFG_DATA_W'(first));
    write_register(sfs_pkg::CFG_FRAME_COUNT, sfs_pkg::CFG_DATA_W'(count));
    write_register(sfs_pkg::CFG_PING_PONG, sfs_pkg::CFG_DATA_W'(pingpong));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_reset_commands();
    send_request(sfs_pkg::CMD_TICK, 16'd5);
    send_request(sfs_pkg::CMD_PLAY, 16'd0);
    send_request(sfs_pkg::CMD_TICK, 16'd0);
    send_request(sfs_pkg::CMD_TICK, 16'hFFFF);
    send_request(sfs_pkg::CMD_TICK, 16'd1);
    send_request(sfs_pkg::CMD_PAUSE, 16'hFFFF);
    send_request(sfs_pkg::CMD_TICK, 16'd7);
    send_request(sfs_pkg::CMD_STOP, 16'd0);
  endtask

  task automatic test_loop_wrap();
    wait_drained();
    load_settings(16'd3, 6'd5, 7'd4, 1'b0);
    send_request(sfs_pkg::CMD_PLAY, 16'd0);
    send_request(sfs_pkg::CMD_TICK, 16'd2);
    send_request(sfs_pkg::CMD_TICK, 16'd1);
    send_request(sfs_pkg::CMD_TICK, 16'd9);
  endtask

  task automatic test_ping_pong();
    wait_drained();
    load_settings(16'd1, 6'd2, 7'd4, 1'b1);
    send_request(sfs_pkg::CMD_STOP, 16'd0);
    send_request(sfs_pkg::CMD_PLAY, 16'd0);
    send_request(sfs_pkg::CMD_TICK, 16'd3);
    send_request(sfs_pkg::CMD_TICK, 16'd1);
    send_request(sfs_pkg::CMD_TICK, 16'd7);
    send_request(sfs_pkg::CMD_TICK, 16'd8);
  endtask

  task automatic test_span_extremes();
    wait_drained();
    load_settings(16'd0, 6'd0, 7'd0, 1'b0);
    send_request(sfs_pkg::CMD_PLAY, 16'd0);
    send_request(sfs_pkg::CMD_TICK, 16'hFFFF);
    wait_drained();
    load_settings(16'd1, 6'd0, 7'd0, 1'b0);
    send_request(sfs_pkg::CMD_TICK, 16'd9);
    wait_drained();
    load_settings(16'hFFFF, 6'd63, 7'd127, 1'b1);
    send_request(sfs_pkg::CMD_TICK, 16'hFFFF);
    send_request(sfs_pkg::CMD_TICK, 16'hFFFE);
    send_request(sfs_pkg::CMD_TICK, 16'hFFFF);
  endtask

  task automatic test_result_stall();
    wait_drained();
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    load_settings(16'd2, 6'd0, 7'd64, 1'b1);
    send_request(sfs_pkg::CMD_PLAY, 16'd0);
    hold_results = 1'b1;
    repeat (STALL_REQUESTS)
      send_request(sfs_pkg::CMD_TICK, sfs_pkg::TICK_W'($urandom_range(0, 5)));
  endtask

  function automatic logic [sfs_pkg::DUR_W-1:0] pick_duration();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'd1;
    if (r < 25) return 16'hFFFF;
    if (r < 28) return 16'd0;
    if (r < 70) return sfs_pkg::DUR_W'($urandom_range(2, 16));
    return sfs_pkg::DUR_W'($urandom_range(1, 65535));
  endfunction

  function automatic logic [sfs_pkg::FRAME_W-1:0] pick_first();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 25) return '1;
    return sfs_pkg::FRAME_W'($urandom_range(0, 63));
  endfunction

  function automatic logic [sfs_pkg::COUNT_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 7'd1;
    if (r < 15) return 7'd0;
    if (r < 20) return 7'd64;
    if (r < 30) return sfs_pkg::COUNT_W'($urandom_range(65, 127));
    return sfs_pkg::COUNT_W'($urandom_range(1, 64));
  endfunction

  function automatic sfs_pkg::cmd_t pick_command();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 72) return sfs_pkg::CMD_TICK;
    if (r < 84) return sfs_pkg::CMD_PLAY;
    if (r < 91) return sfs_pkg::CMD_PAUSE;
    return sfs_pkg::CMD_STOP;
  endfunction

  function automatic logic [sfs_pkg::TICK_W-1:0] pick_elapsed(
      input logic [sfs_pkg::DUR_W-1:0] duration);
    int unsigned r;
    int unsigned hi;
    r  = $urandom_range(0, 99);
    hi = 2 * int'(duration);
    if (hi > 65535) hi = 65535;
    if (r < 35) return sfs_pkg::TICK_W'($urandom_range(0, hi));
    if (r < 55) return sfs_pkg::TICK_W'($urandom_range(0, 3));
    if (r < 60) return 16'hFFFF;
    return sfs_pkg::TICK_W'($urandom_range(0, 65535));
  endfunction

  task automatic test_random_play();
    logic [sfs_pkg::DUR_W-1:0] duration;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained();
      sender_idle   = (phase % 3) != 0;
      receiver_idle = (phase % 2) != 0;
      duration      = pick_duration();
      load_settings(duration, pick_first(), pick_count(), 1'($urandom_range(0, 1)));
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if ($urandom_range(0, 79) == 0) wait_drained();
        send_request(pick_command(), pick_elapsed(duration));
      end
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.cmd           <= sfs_pkg::CMD_TICK;
    in_ch.elapsed_ticks <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= sfs_pkg::CFG_FRAME_DURATION;
    cfg_ch.data         <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_commands();
    test_loop_wrap();
    test_ping_pong();
    test_span_extremes();
    test_result_stall();
    test_random_play();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_status_q.size() == 0) begin
      $display("sprite_frame_sequencer regression: pass");
    end else begin
      $display("sprite_frame_sequencer regression: fail");
    end
    $finish;
  end

endmodule

/* sprite_frame_sequencer.f */
+incdir+hdl
hdl/sfs_pkg.sv
hdl/sfs_chan_if.sv
hdl/sfs_div.sv
hdl/sprite_frame_sequencer.sv
test/tb_sprite_frame_sequencer.sv
